// ----- rtl/core/swqt_pkg.sv -----
// Package for the semaphore wait queue table: payload structs, opcodes and status codes.
// No dependencies.
package swqt_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned KeyW = 32;
  localparam int unsigned PidW = 5;
  localparam int unsigned StW  = 2;
  localparam int unsigned MaxOut = 32;

  localparam logic [OpW-1:0] OP_BLOCK  = 3'd0;
  localparam logic [OpW-1:0] OP_POP    = 3'd1;
  localparam logic [OpW-1:0] OP_PEEK   = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd3;
  localparam logic [OpW-1:0] OP_LIST   = 3'd4;

  localparam logic [StW-1:0] ST_OK       = 2'd0;
  localparam logic [StW-1:0] ST_NO_DESC  = 2'd1;
  localparam logic [StW-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [KeyW-1:0] sem_key;
    logic [PidW-1:0] proc_id;
  } req_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [PidW-1:0] proc_out;
    logic            proc_valid;
    logic            last;
  } rsp_t;

endpackage

// ----- rtl/core/semaphore_wait_queue_table.sv -----
// Top level of the semaphore wait queue table: sequencer over the descriptor and process memories.
// Depends on swqt_pkg.
//
//  channel  | valid     | stall     | payload
//  request  | req_valid_i | req_stall_o | req_i (req_t)
//  response | rsp_valid_o | rsp_stall_i | rsp_o (rsp_t)
//
// One request at a time. Each memory access is an address state followed by a state that uses
// the registered read data, so every chain or queue entry visited costs one such pair on top
// of the opcode's own states.
// After reset a clearing pass over max(MAX_SEMD, MAX_PROC) entries runs before the first transfer.
// A stalled response holds; the next request waits until the response is taken.
module semaphore_wait_queue_table
  import swqt_pkg::*;
#(
  parameter int unsigned MAX_SEMD     = 32,
  parameter int unsigned HASH_BUCKETS = 8,
  parameter int unsigned MAX_PROC     = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  localparam int unsigned DW = (MAX_SEMD > 1) ? $clog2(MAX_SEMD) : 1;
  localparam int unsigned BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int unsigned PW = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
  localparam int unsigned CLRN = (MAX_SEMD > MAX_PROC) ? MAX_SEMD : MAX_PROC;
  localparam int unsigned CW = $clog2(CLRN + 1);
  localparam int unsigned HW = $clog2(MAX_SEMD) + 1;
  localparam int unsigned ListW = $clog2(MaxOut + 1);

  // descriptor memory entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            nx_v;
    logic [DW-1:0]   nx;
    logic            qh_v;
    logic [PW-1:0]   qh;
    logic [PW-1:0]   qt;
  } desc_t;

  // process memory entry
  typedef struct packed {
    logic [KeyW-1:0] wkey;
    logic            lk_v;
    logic [PW-1:0]   lk;
  } pent_t;

  typedef enum logic [19:0] {
    S_CLR    = 20'h00001,
    S_IDLE   = 20'h00002,
    S_PRD    = 20'h00004,
    S_PCHK   = 20'h00008,
    S_FRD    = 20'h00010,
    S_FCHK   = 20'h00020,
    S_ALLOC  = 20'h00040,
    S_APPEND = 20'h00080,
    S_TLRD   = 20'h00100,
    S_TLWR   = 20'h00200,
    S_HEAD   = 20'h00400,
    S_HDCHK  = 20'h00800,
    S_WALK   = 20'h01000,
    S_WCHK   = 20'h02000,
    S_UNLNK  = 20'h04000,
    S_REL    = 20'h08000,
    S_RCHK   = 20'h10000,
    S_LRD    = 20'h20000,
    S_LCHK   = 20'h40000,
    S_OUT    = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // memories
  desc_t dmem [MAX_SEMD];
  pent_t pmem [MAX_PROC];
  logic          d_we, p_we;
  logic [DW-1:0] d_wa, d_ra;
  logic [PW-1:0] p_wa, p_ra;
  desc_t d_wd, d_rd;
  pent_t p_wd, p_rd;

  always_ff @(posedge clk_i) begin
    if (d_we) dmem[d_wa] <= d_wd;
    d_rd <= dmem[d_ra];
  end
  always_ff @(posedge clk_i) begin
    if (p_we) pmem[p_wa] <= p_wd;
    p_rd <= pmem[p_ra];
  end

  // small register state
  logic [HASH_BUCKETS-1:0] bh_v_q, bh_v_d;
  logic [DW-1:0] bh_q [HASH_BUCKETS];
  logic [DW-1:0] bh_d [HASH_BUCKETS];
  logic          fh_v_q, fh_v_d;
  logic [DW-1:0] fh_q, fh_d;

  req_t          req_q, req_d;
  logic [KeyW-1:0] key_q, key_d;   // key being searched
  logic [BW-1:0] bkt_q, bkt_d;
  logic [DW-1:0] cur_q, cur_d;     // descriptor cursor
  logic [DW-1:0] dsel_q, dsel_d;   // found descriptor
  desc_t         dent_q, dent_d;   // copy of found descriptor
  logic          prv_v_q, prv_v_d;
  logic [DW-1:0] prv_q, prv_d;     // chain predecessor
  logic [PW-1:0] pc_q, pc_d;       // process cursor
  logic          pp_v_q, pp_v_d;
  logic [PW-1:0] pp_q, pp_d;       // queue predecessor
  logic [CW-1:0] cnt_q, cnt_d;
  logic [ListW-1:0] lcnt_q, lcnt_d;
  logic          rel_q, rel_d;     // release pending after search
  logic          found_act_q, found_act_d; // search result action: 0 op, 1 release
  logic          rsp_v_q, rsp_v_d;
  rsp_t          rsp_q, rsp_d;

  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;
  assign req_stall_o = (state_q != S_IDLE) || rsp_v_q;

  function automatic logic [BW-1:0] hash_f(input logic [KeyW-1:0] k);
    logic [KeyW+3:0] h;
    logic [HW-1:0]   m;
    h = {4'd0, k} * (KeyW+4)'(11) + (KeyW+4)'(1);
    m = HW'(h % MAX_SEMD);
    return BW'(m % HASH_BUCKETS);
  endfunction

  logic rsp_free;
  assign rsp_free = !rsp_v_q || !rsp_stall_i;

  always_comb begin
    state_d = state_q;
    bh_v_d = bh_v_q; bh_d = bh_q; fh_v_d = fh_v_q; fh_d = fh_q;
    req_d = req_q; key_d = key_q; bkt_d = bkt_q; cur_d = cur_q; dsel_d = dsel_q;
    dent_d = dent_q; prv_v_d = prv_v_q; prv_d = prv_q; pc_d = pc_q; pp_v_d = pp_v_q;
    pp_d = pp_q; cnt_d = cnt_q; lcnt_d = lcnt_q; rel_d = rel_q; found_act_d = found_act_q;
    rsp_v_d = rsp_v_q && rsp_stall_i; rsp_d = rsp_q;
    d_we = 1'b0; d_wa = cur_q; d_wd = d_rd; d_ra = cur_q;
    p_we = 1'b0; p_wa = pc_q;  p_wd = p_rd; p_ra = pc_q;

    unique case (state_q)
      S_CLR: begin
        if (cnt_q < CW'(MAX_SEMD)) begin
          d_we = 1'b1; d_wa = DW'(cnt_q);
          d_wd = '0;
          d_wd.nx_v = (cnt_q + CW'(1)) < CW'(MAX_SEMD);
          d_wd.nx = DW'(cnt_q + CW'(1));
        end
        if (cnt_q < CW'(MAX_PROC)) begin
          p_we = 1'b1; p_wa = PW'(cnt_q); p_wd = '0;
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(CLRN - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i && !rsp_v_q) begin
          req_d = req_i;
          rel_d = 1'b0;
          rsp_d = '{status: ST_OK, proc_out: '0, proc_valid: 1'b0, last: 1'b1};
          if (req_i.opcode == OP_BLOCK || req_i.opcode == OP_REMOVE) begin
            if (32'(req_i.proc_id) >= MAX_PROC ||
                (req_i.opcode == OP_BLOCK && req_i.sem_key == '0)) begin
              rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1;
            end else begin
              pc_d = PW'(req_i.proc_id); state_d = S_PRD;
            end
          end else if (req_i.opcode == OP_POP || req_i.opcode == OP_PEEK ||
                       req_i.opcode == OP_LIST) begin
            key_d = req_i.sem_key;
            bkt_d = hash_f(req_i.sem_key);
            if (req_i.sem_key == '0 || !bh_v_q[hash_f(req_i.sem_key)]) begin
              rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1;
            end else begin
              cur_d = bh_q[hash_f(req_i.sem_key)]; prv_v_d = 1'b0; cnt_d = '0;
              state_d = S_FRD;
            end
          end else begin
            rsp_v_d = 1'b1;
          end
        end
      end
      S_PRD: state_d = S_PCHK;   // process entry read in flight
      S_PCHK: begin
        if (req_q.opcode == OP_BLOCK) begin
          if (p_rd.wkey != '0) begin
            rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
          end else key_d = req_q.sem_key;
        end else begin
          if (p_rd.wkey == '0) begin
            rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
          end else key_d = p_rd.wkey;
        end
        if (!(req_q.opcode == OP_BLOCK ? (p_rd.wkey != '0) : (p_rd.wkey == '0))) begin
          bkt_d = hash_f(key_d); prv_v_d = 1'b0; cnt_d = '0;
          if (!bh_v_q[hash_f(key_d)]) begin
            if (req_q.opcode == OP_BLOCK) state_d = S_ALLOC;
            else begin
              rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
            end
          end else begin
            cur_d = bh_q[hash_f(key_d)]; state_d = S_FRD;
          end
        end
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (d_rd.key == key_q) begin
          dsel_d = cur_q; dent_d = d_rd;
          if (rel_q) begin
            // unlink from bucket chain, push to free list
            if (!prv_v_q) begin
              bh_v_d[bkt_q] = d_rd.nx_v; bh_d[bkt_q] = d_rd.nx;
              state_d = S_RCHK;
            end else begin
              state_d = S_REL;
            end
          end else if (req_q.opcode == OP_BLOCK) state_d = S_APPEND;
          else if (req_q.opcode == OP_REMOVE) begin
            pp_v_d = 1'b0; cnt_d = '0;
            if (!d_rd.qh_v) begin
              rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
            end else begin
              pc_d = d_rd.qh; state_d = S_WALK;
            end
          end else begin
            if (!d_rd.qh_v) begin
              rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
            end else begin
              pc_d = d_rd.qh;
              lcnt_d = '0;
              state_d = (req_q.opcode == OP_LIST) ? S_LRD : S_HEAD;
            end
          end
        end else if (!d_rd.nx_v || cnt_q == CW'(MAX_SEMD - 1)) begin
          if (req_q.opcode == OP_BLOCK && !rel_q) state_d = S_ALLOC;
          else begin
            rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
          end
        end else begin
          prv_v_d = 1'b1; prv_d = cur_q; cur_d = d_rd.nx; cnt_d = cnt_q + CW'(1);
          state_d = S_FRD;
        end
      end
      S_ALLOC: begin
        // read free head's entry to learn its next
        if (!fh_v_q) begin
          rsp_d.status = ST_NO_DESC; rsp_v_d = 1'b1; state_d = S_IDLE;
        end else begin
          d_ra = fh_q; cur_d = fh_q; state_d = S_TLRD; rel_d = 1'b1;
        end
      end
      S_TLRD: begin
        if (rel_q) begin
          // new descriptor: d_rd is the free-head entry
          fh_v_d = d_rd.nx_v; fh_d = d_rd.nx;
          d_we = 1'b1; d_wa = cur_q;
          d_wd.key = key_q; d_wd.nx_v = bh_v_q[bkt_q]; d_wd.nx = bh_q[bkt_q];
          d_wd.qh_v = 1'b1; d_wd.qh = PW'(req_q.proc_id); d_wd.qt = PW'(req_q.proc_id);
          bh_v_d[bkt_q] = 1'b1; bh_d[bkt_q] = cur_q;
          rel_d = 1'b0;
          p_we = 1'b1; p_wa = PW'(req_q.proc_id);
          p_wd = '{wkey: key_q, lk_v: 1'b0, lk: '0};
          rsp_v_d = 1'b1; state_d = S_IDLE;
        end else state_d = S_TLWR;
      end
      S_APPEND: begin
        // existing descriptor dent_q
        d_we = 1'b1; d_wa = dsel_q; d_wd = dent_q;
        if (!dent_q.qh_v) begin d_wd.qh_v = 1'b1; d_wd.qh = PW'(req_q.proc_id); end
        d_wd.qt = PW'(req_q.proc_id);
        p_we = 1'b1; p_wa = PW'(req_q.proc_id);
        p_wd = '{wkey: key_q, lk_v: 1'b0, lk: '0};
        if (dent_q.qh_v) begin
          pc_d = dent_q.qt; state_d = S_TLRD;
        end else begin
          rsp_v_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_TLWR: begin
        // old tail entry read; point its link at the new process
        p_we = 1'b1; p_wa = pc_q; p_wd = p_rd;
        p_wd.lk_v = 1'b1; p_wd.lk = PW'(req_q.proc_id);
        rsp_v_d = 1'b1; state_d = S_IDLE;
      end
      S_HEAD: state_d = S_HDCHK;
      S_HDCHK: begin
        rsp_d.proc_out = PidW'(pc_q); rsp_d.proc_valid = 1'b1;
        if (req_q.opcode == OP_POP) begin
          p_we = 1'b1; p_wa = pc_q; p_wd = '0;
          d_we = 1'b1; d_wa = dsel_q; d_wd = dent_q;
          d_wd.qh_v = p_rd.lk_v; d_wd.qh = p_rd.lk;
          dent_d = d_wd;
          if (!p_rd.lk_v) begin
            rel_d = 1'b1; state_d = S_RCHK;
            cur_d = dsel_q;
            if (bh_q[bkt_q] == dsel_q) begin
              bh_v_d[bkt_q] = dent_q.nx_v; bh_d[bkt_q] = dent_q.nx;
            end else begin
              cur_d = bh_q[bkt_q]; cnt_d = '0; state_d = S_REL;
            end
          end else begin
            rsp_v_d = 1'b1; state_d = S_IDLE;
          end
        end else begin
          rsp_v_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_WALK: state_d = S_WCHK;
      S_WCHK: begin
        if (pc_q == PW'(req_q.proc_id)) begin
          state_d = S_UNLNK;
          p_we = 1'b1; p_wa = pc_q; p_wd = '0;
          d_we = 1'b1; d_wa = dsel_q; d_wd = dent_q;
          if (!pp_v_q) begin d_wd.qh_v = p_rd.lk_v; d_wd.qh = p_rd.lk; end
          if (dent_q.qt == pc_q) d_wd.qt = pp_q;
          dent_d = d_wd;
          pc_d = pp_q; rel_d = p_rd.lk_v; // keep link for predecessor
          found_act_d = p_rd.lk_v;
          pp_d = p_rd.lk;
          if (!pp_v_q && !p_rd.lk_v) state_d = S_UNLNK;
        end else if (!p_rd.lk_v || cnt_q == CW'(MAX_PROC - 1)) begin
          rsp_d.status = ST_NOT_FOUND; rsp_v_d = 1'b1; state_d = S_IDLE;
        end else begin
          pp_v_d = 1'b1; pp_d = pc_q; pc_d = p_rd.lk; cnt_d = cnt_q + CW'(1);
          state_d = S_WALK;
        end
      end
      S_UNLNK: begin
        // predecessor link gets removed process's link; then release if queue empty
        if (pp_v_q) begin
          p_we = 1'b1; p_wa = pc_q; p_wd = '{wkey: '0, lk_v: found_act_q, lk: pp_d};
          p_wd.wkey = key_q;
          p_wd.lk = pp_q; // pp_q holds removed process's link here
        end
        rel_d = 1'b0;
        if (!dent_q.qh_v) begin
          rel_d = 1'b1; cur_d = dsel_q;
          if (bh_q[bkt_q] == dsel_q) begin
            bh_v_d[bkt_q] = dent_q.nx_v; bh_d[bkt_q] = dent_q.nx;
            state_d = S_RCHK;
          end else begin
            cur_d = bh_q[bkt_q]; cnt_d = '0; state_d = S_REL;
          end
        end else begin
          rsp_v_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_REL: begin
        // walking the bucket chain to find dsel's predecessor; cur is read address
        d_ra = cur_q; state_d = S_LCHK; found_act_d = 1'b1;
      end
      S_LCHK: begin
        if (found_act_q) begin
          if (d_rd.nx_v && d_rd.nx == dsel_q) begin
            d_we = 1'b1; d_wa = cur_q; d_wd = d_rd;
            d_wd.nx_v = dent_q.nx_v; d_wd.nx = dent_q.nx;
            state_d = S_RCHK; cur_d = dsel_q;
          end else if (!d_rd.nx_v || cnt_q == CW'(MAX_SEMD - 1)) begin
            state_d = S_RCHK; cur_d = dsel_q;
          end else begin
            cur_d = d_rd.nx; cnt_d = cnt_q + CW'(1); state_d = S_REL;
          end
          found_act_d = 1'b0;
        end else begin
          // list step: p_rd is entry of pc
          rsp_d.proc_out = PidW'(pc_q); rsp_d.proc_valid = 1'b1; rsp_d.status = ST_OK;
          rsp_d.last = !p_rd.lk_v || lcnt_q == ListW'(MaxOut - 1);
          rsp_v_d = 1'b1;
          pc_d = p_rd.lk; lcnt_d = lcnt_q + ListW'(1);
          state_d = rsp_d.last ? S_IDLE : S_OUT;
        end
      end
      S_RCHK: begin
        // free the descriptor
        d_we = 1'b1; d_wa = dsel_q;
        d_wd = '{key: '0, nx_v: fh_v_q, nx: fh_q, qh_v: 1'b0, qh: '0, qt: '0};
        fh_v_d = 1'b1; fh_d = dsel_q; rel_d = 1'b0;
        rsp_v_d = 1'b1; state_d = S_IDLE;
      end
      S_LRD: begin
        found_act_d = 1'b0; state_d = S_LCHK;
      end
      S_OUT: begin
        if (rsp_free) state_d = S_LRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      bh_v_q <= '0; fh_v_q <= 1'b1; fh_q <= '0;
      cnt_q <= '0; lcnt_q <= '0; rel_q <= 1'b0; found_act_q <= 1'b0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bh_v_q <= bh_v_d; fh_v_q <= fh_v_d; fh_q <= fh_d;
      cnt_q <= cnt_d; lcnt_q <= lcnt_d; rel_q <= rel_d; found_act_q <= found_act_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bh_q <= bh_d; req_q <= req_d; key_q <= key_d; bkt_q <= bkt_d; cur_q <= cur_d;
    dsel_q <= dsel_d; dent_q <= dent_d; prv_v_q <= prv_v_d; prv_q <= prv_d;
    pc_q <= pc_d; pp_v_q <= pp_v_d; pp_q <= pp_d; rsp_q <= rsp_d;
  end

endmodule

// ----- verif/tb_semaphore_wait_queue_table.sv -----
// Self-checking bench for semaphore_wait_queue_table: own model of the descriptor pool,
// hash buckets and wait queues, scoreboard class, random gaps and stalls. Depends on swqt_pkg.
module tb_semaphore_wait_queue_table;
  timeunit 1ns;
  timeprecision 1ps;
  import swqt_pkg::*;

  localparam int NSEMD = 32;
  localparam int NBKT = 8;
  localparam int NPROC = 32;
  localparam int NONE = 255;
  localparam int CYCLE_LIMIT = 2000000;

  class sem_table_sb;
    int bkt_head[NBKT];
    logic [31:0] dkey[NSEMD];
    int dnext[NSEMD];
    int qhead[NSEMD];
    int qtail[NSEMD];
    int free_ptr;
    int plink[NPROC];
    logic [31:0] pkey[NPROC];
    rsp_t pending[$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < NBKT; i++) bkt_head[i] = NONE;
      for (int i = 0; i < NSEMD; i++) begin
        dkey[i] = 0;
        dnext[i] = (i + 1 < NSEMD) ? i + 1 : NONE;
        qhead[i] = NONE;
        qtail[i] = NONE;
      end
      free_ptr = 0;
      for (int i = 0; i < NPROC; i++) begin
        plink[i] = NONE;
        pkey[i] = 0;
      end
    endfunction

    function int hash_bkt(logic [31:0] k);
      logic [63:0] h;
      h = (64'd11 * {32'd0, k} + 64'd1) % NSEMD;
      return int'(h % NBKT);
    endfunction

    function int lookup(logic [31:0] k);
      int d;
      d = bkt_head[hash_bkt(k)];
      if (k == 0) return NONE;
      for (int n = 0; n < NSEMD && d < NSEMD; n++) begin
        if (dkey[d] == k) return d;
        d = dnext[d];
      end
      return NONE;
    endfunction

    function void free_desc(int d);
      int b;
      int c;
      b = hash_bkt(dkey[d]);
      c = bkt_head[b];
      if (c == d) bkt_head[b] = dnext[d];
      else begin
        for (int n = 0; n < NSEMD && c < NSEMD; n++) begin
          if (dnext[c] == d) begin
            dnext[c] = dnext[d];
            break;
          end
          c = dnext[c];
        end
      end
      dkey[d] = 0;
      qhead[d] = NONE;
      qtail[d] = NONE;
      dnext[d] = free_ptr;
      free_ptr = d;
    endfunction

    function void push(logic [StW-1:0] st, int p, bit v, bit l);
      rsp_t r;
      r.status = st;
      r.proc_out = p[PidW-1:0];
      r.proc_valid = v;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void note_request(req_t rq);
      int d, q, prev, b, p, k, nx;
      logic [31:0] key;
      key = rq.sem_key;
      p = rq.proc_id;
      case (rq.opcode)
        OP_BLOCK: begin
          if (key == 0 || pkey[p] != 0) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          d = lookup(key);
          if (d == NONE) begin
            if (free_ptr >= NSEMD) begin
              push(ST_NO_DESC, 0, 0, 1);
              return;
            end
            d = free_ptr;
            free_ptr = dnext[d];
            b = hash_bkt(key);
            dnext[d] = bkt_head[b];
            bkt_head[b] = d;
            dkey[d] = key;
            qhead[d] = NONE;
            qtail[d] = NONE;
          end
          plink[p] = NONE;
          if (qtail[d] < NPROC) plink[qtail[d]] = p;
          else qhead[d] = p;
          qtail[d] = p;
          pkey[p] = key;
          push(ST_OK, 0, 0, 1);
        end
        OP_POP, OP_PEEK: begin
          d = lookup(key);
          if (d == NONE || qhead[d] >= NPROC) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          q = qhead[d];
          if (rq.opcode == OP_POP) begin
            qhead[d] = plink[q];
            if (qhead[d] >= NPROC) free_desc(d);
            plink[q] = NONE;
            pkey[q] = 0;
          end
          push(ST_OK, q, 1, 1);
        end
        OP_REMOVE: begin
          if (pkey[p] == 0) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          d = lookup(pkey[p]);
          if (d == NONE) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          prev = NONE;
          q = qhead[d];
          for (int n = 0; n < NPROC && q < NPROC && q != p; n++) begin
            prev = q;
            q = plink[q];
          end
          if (q != p) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          if (prev == NONE) qhead[d] = plink[p];
          else plink[prev] = plink[p];
          if (qtail[d] == p) qtail[d] = prev;
          plink[p] = NONE;
          pkey[p] = 0;
          if (qhead[d] >= NPROC) free_desc(d);
          push(ST_OK, 0, 0, 1);
        end
        OP_LIST: begin
          d = lookup(key);
          if (d == NONE || qhead[d] >= NPROC) begin
            push(ST_NOT_FOUND, 0, 0, 1);
            return;
          end
          k = 0;
          q = qhead[d];
          while (k < MaxOut && q < NPROC) begin
            nx = plink[q];
            push(ST_OK, q, 1, (nx >= NPROC || k == MaxOut - 1));
            k++;
            q = nx;
          end
        end
        default: push(ST_OK, 0, 0, 1);
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rsp_t rsp_o;

  sem_table_sb sb = new();
  bit hold_off = 1'b0;
  int cycles = 0;
  logic [31:0] keys[8];

  semaphore_wait_queue_table dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("semaphore_wait_queue_table: mismatch");
      $finish;
    end
  end

  // response side: check every transfer, random stall per result, long hold-off on demand
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (hold_off) gap = 400;
      if (gap > 0) begin
        rsp_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      rsp_stall_i <= 1'b0;
      do @(posedge clk_i); while (!rsp_valid_o);
      sb.check_response(rsp_o);
    end
  end

  task automatic send(logic [2:0] op, logic [31:0] key, logic [4:0] pid, int gap);
    req_t r;
    r.opcode = op;
    r.sem_key = key;
    r.proc_id = pid;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(r);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom() : keys[$urandom_range(0, 7)];
  endfunction

  initial begin
    int gap;
    int opsel;
    keys[0] = 32'hFFFF_FFFF;
    keys[1] = 32'h1;
    keys[2] = 32'h8000_0000;
    for (int i = 3; i < 8; i++) keys[i] = $urandom() | 32'h1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every opcode, error cases
    send(OP_BLOCK, 32'h0, 5'd0, 0);
    send(OP_POP, 32'h5, 5'd0, 0);
    send(OP_PEEK, 32'h5, 5'd0, 0);
    send(OP_LIST, 32'h5, 5'd0, 0);
    send(OP_REMOVE, 32'h0, 5'd31, 0);
    send(OP_BLOCK, 32'hFFFF_FFFF, 5'd31, 0);
    send(OP_BLOCK, 32'hFFFF_FFFF, 5'd31, 0);
    send(OP_BLOCK, 32'hFFFF_FFFF, 5'd0, 0);
    send(OP_BLOCK, 32'h8000_0000, 5'd1, 0);
    send(OP_PEEK, 32'hFFFF_FFFF, 5'd0, 0);
    send(OP_LIST, 32'hFFFF_FFFF, 5'd0, 0);
    send(OP_REMOVE, 32'h0, 5'd0, 0);
    send(OP_REMOVE, 32'h0, 5'd0, 0);
    send(OP_POP, 32'hFFFF_FFFF, 5'd0, 0);
    send(OP_POP, 32'h8000_0000, 5'd0, 0);
    send(3'd5, 32'h1, 5'd3, 0);
    send(3'd7, 32'hFFFF_FFFF, 5'd31, 0);
    // all 32 processes on one key: full-length list, then drain
    for (int p = 0; p < 32; p++) send(OP_BLOCK, 32'h1, p[4:0], $urandom_range(0, 2));
    send(OP_LIST, 32'h1, 5'd0, 0);
    for (int p = 0; p < 32; p++) send(OP_POP, 32'h1, 5'd0, 0);
    // pool exhaustion: 32 distinct keys, then one more
    for (int p = 0; p < 32; p++) send(OP_BLOCK, 32'h100 + p, p[4:0], 0);
    send(OP_BLOCK, 32'hABCD, 5'd0, 0);
    for (int p = 0; p < 32; p++) send(OP_REMOVE, 32'h0, p[4:0], 0);
    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) send(OP_BLOCK, keys[i % 8], i[4:0], 0);
    hold_off = 1'b0;
    for (int i = 0; i < 460; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      opsel = $urandom_range(0, 19);
      if (opsel < 8) send(OP_BLOCK, pick_key(), $urandom(), gap);
      else if (opsel < 11) send(OP_POP, pick_key(), $urandom(), gap);
      else if (opsel < 13) send(OP_PEEK, pick_key(), $urandom(), gap);
      else if (opsel < 16) send(OP_REMOVE, $urandom(), $urandom(), gap);
      else if (opsel < 19) send(OP_LIST, pick_key(), $urandom(), gap);
      else send($urandom_range(5, 7), $urandom(), $urandom(), gap);
    end
    req_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("semaphore_wait_queue_table: match");
    end else begin
      $display("semaphore_wait_queue_table: mismatch");
    end
    $finish;
  end
endmodule
